[hdl/hrhp_pkg.sv]
`default_nettype none
package hrhp_pkg;
    localparam int MAX_HEADERS_DEF = 64;
    localparam int LEN_WIDTH_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_LINE    = 3'd3;
    localparam logic [2:0] PH_NAME    = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [2:0] RL_METHOD = 3'd0;
    localparam logic [2:0] RL_PATH   = 3'd1;
    localparam logic [2:0] RL_VER    = 3'd2;
    localparam logic [2:0] RL_NAME   = 3'd3;
    localparam logic [2:0] RL_VALUE  = 3'd4;
    localparam logic [2:0] RL_BODY   = 3'd5;
    localparam logic [2:0] RL_DELIM  = 3'd6;

    localparam logic [1:0] VP_LEAD  = 2'd0;
    localparam logic [1:0] VP_DIGIT = 2'd1;
    localparam logic [1:0] VP_TRAIL = 2'd2;

    localparam logic [3:0] CL_NAME_LEN = 4'd14;

    function automatic logic is_token(input logic [7:0] c);
        logic r;
        r = 1'b0;
        if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
            (c >= 8'h30 && c <= 8'h39))
            r = 1'b1;
        else
            r = c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                          8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e};
        return r;
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd0: r = 8'h48;
            4'd1: r = 8'h54;
            4'd2: r = 8'h54;
            4'd3: r = 8'h50;
            4'd4: r = 8'h2f;
            4'd5: r = 8'h31;
            default: r = 8'h2e;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd0: r = 8'h63;
            4'd1: r = 8'h6f;
            4'd2: r = 8'h6e;
            4'd3: r = 8'h74;
            4'd4: r = 8'h65;
            4'd5: r = 8'h6e;
            4'd6: r = 8'h74;
            4'd7: r = 8'h2d;
            4'd8: r = 8'h6c;
            4'd9: r = 8'h65;
            4'd10: r = 8'h6e;
            4'd11: r = 8'h67;
            4'd12: r = 8'h74;
            4'd13: r = 8'h68;
            default: r = 8'h00;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hdl/http_request_header_parser.sv]
`default_nettype none
// http/1.x request header parser. one byte is taken per item on s_axis and one
// result item leaves on m_axis for every byte, one item per clock when the
// output side keeps tready high: a single state update per byte sits between
// the input handshake and the output register, which takes the next byte
// only when empty or as its result leaves. status says need more, complete or
// malformed; after complete or malformed the parser starts over on the next
// byte. restart in tuser clears all state before its byte.
module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int MAX_HEADERS = MAX_HEADERS_DEF,
    parameter int LEN_WIDTH   = LEN_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data byte
    input  wire logic         s_axis_tuser,   // restart
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [119:0]      m_axis_tdata    // status, byte role, header index,
                                              // method length, path length,
                                              // version minor, header count,
                                              // content length, byte count, zero pad
);
    localparam logic [LEN_WIDTH-1:0]   LEN_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [6:0] HDR_LIMIT = 7'(MAX_HEADERS > 127 ? 127 : MAX_HEADERS);

    logic [2:0]  phase_reg, phase_next, ph;
    logic [3:0]  lit_reg, lit_next, lit;
    logic        pcr_reg, pcr_next, pcr;
    logic [LEN_WIDTH-1:0] mcnt_reg, mcnt_next, mc, pcnt_reg, pcnt_next, pc;
    logic        minor_reg, minor_next, mn;
    logic [6:0]  hseen_reg, hseen_next, hs;
    logic [3:0]  nmp_reg, nmp_next, nmp;
    logic        nm_reg, nm_next, nm;
    logic [1:0]  vp_reg, vp_next, vp;
    logic [31:0] acc_reg, acc_next, acc, lval_reg, lval_next, lv, bl_reg, bl_next, bl;
    logic        lseen_reg, lseen_next, ls;
    logic [COUNT_WIDTH-1:0] tot_reg, tot_next, tt;
    logic [119:0] out_reg, out_next;
    logic        ov_reg;
    logic        take, err, done, is_cl;
    logic [1:0]  st;
    logic [2:0]  role;
    logic [6:0]  hidx;
    logic [7:0]  b;
    logic [31:0] acc_base;
    logic [35:0] acc10;
    logic [3:0]  dgt;

    assign s_axis_tready = !ov_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;
    assign b = s_axis_tdata;
    assign dgt = 4'(b - 8'h30);
    // accumulator as seen by this byte, after an optional restart
    assign acc_base = s_axis_tuser ? 32'd0 : acc_reg;
    assign acc10 = {4'd0, acc_base} * 36'd10 + {32'd0, dgt};

    always_comb
    begin
        // state after an optional restart
        ph = phase_reg; lit = lit_reg; pcr = pcr_reg; mc = mcnt_reg; pc = pcnt_reg;
        mn = minor_reg; hs = hseen_reg; nmp = nmp_reg; nm = nm_reg; vp = vp_reg;
        acc = acc_reg; lv = lval_reg; ls = lseen_reg; bl = bl_reg; tt = tot_reg;
        if (s_axis_tuser)
        begin
            ph = PH_METHOD; lit = '0; pcr = 1'b0; mc = '0; pc = '0; mn = 1'b0;
            hs = '0; nmp = '0; nm = 1'b1; vp = VP_LEAD; acc = '0; lv = '0;
            ls = 1'b0; bl = '0; tt = '0;
        end
        if (tt != CNT_MAX)
            tt = tt + 1'b1;
        is_cl = nm && nmp == CL_NAME_LEN;
        err = 1'b0; done = 1'b0; role = RL_METHOD; hidx = '0;

        if (pcr)
        begin
            role = RL_DELIM;
            pcr = 1'b0;
            if (ph == PH_VALUE)
                hidx = hs - 1'b1;
            if (b != 8'h0a)
                err = 1'b1;
            else if (ph == PH_LINE)
            begin
                if (lv == '0)
                    done = 1'b1;
                else
                begin
                    bl = lv;
                    ph = PH_BODY;
                end
            end
            else
                ph = PH_LINE;
        end
        else
        begin
            case (ph)
                PH_METHOD:
                begin
                    if (b == 8'h20)
                    begin
                        role = RL_DELIM;
                        if (mc == '0) err = 1'b1; else ph = PH_PATH;
                    end
                    else if (is_token(b))
                    begin
                        if (mc != LEN_MAX) mc = mc + 1'b1;
                    end
                    else
                        err = 1'b1;
                end
                PH_PATH:
                begin
                    role = RL_PATH;
                    if (b == 8'h20)
                    begin
                        role = RL_DELIM;
                        if (pc == '0) err = 1'b1;
                        else
                        begin
                            ph = PH_VERSION;
                            lit = '0;
                        end
                    end
                    else if (b == 8'h0d || b == 8'h0a)
                        err = 1'b1;
                    else if (pc != LEN_MAX)
                        pc = pc + 1'b1;
                end
                PH_VERSION:
                begin
                    role = RL_VER;
                    if (lit < 4'd7)
                    begin
                        if (b != version_char(lit)) err = 1'b1; else lit = lit + 1'b1;
                    end
                    else if (lit == 4'd7)
                    begin
                        if (b == 8'h30 || b == 8'h31)
                        begin
                            mn = b[0];
                            lit = 4'd8;
                        end
                        else
                            err = 1'b1;
                    end
                    else
                    begin
                        role = RL_DELIM;
                        if (b == 8'h0d) pcr = 1'b1; else err = 1'b1;
                    end
                end
                PH_LINE:
                begin
                    role = RL_NAME;
                    if (b == 8'h0d)
                    begin
                        role = RL_DELIM;
                        pcr = 1'b1;
                    end
                    else if (is_token(b) && hs < HDR_LIMIT)
                    begin
                        hidx = hs;
                        ph = PH_NAME;
                        // first name character, matching restarts here
                        if ((b | ((b >= 8'h41 && b <= 8'h5a) ? 8'h20 : 8'h00))
                            == cl_char(4'd0))
                        begin
                            nm = 1'b1;
                            nmp = 4'd1;
                        end
                        else
                        begin
                            nm = 1'b0;
                            nmp = '0;
                        end
                    end
                    else
                        err = 1'b1;
                end
                PH_NAME:
                begin
                    role = RL_NAME;
                    hidx = hs;
                    if (b == 8'h3a)
                    begin
                        role = RL_DELIM;
                        hs = hs + 1'b1;
                        ph = PH_VALUE;
                        vp = VP_LEAD;
                        acc = '0;
                    end
                    else if (is_token(b))
                    begin
                        if (nm)
                        begin
                            if (nmp < CL_NAME_LEN && (b | ((b >= 8'h41 && b <= 8'h5a) ?
                                8'h20 : 8'h00)) == cl_char(nmp))
                                nmp = nmp + 1'b1;
                            else
                                nm = 1'b0;
                        end
                    end
                    else
                        err = 1'b1;
                end
                PH_VALUE:
                begin
                    role = RL_VALUE;
                    hidx = hs - 1'b1;
                    if (b == 8'h0a)
                        err = 1'b1;
                    else if (b == 8'h0d)
                    begin
                        role = RL_DELIM;
                        pcr = 1'b1;
                        if (is_cl)
                        begin
                            if (vp == VP_LEAD) err = 1'b1;
                            else if (ls && acc != lv) err = 1'b1;
                            else
                            begin
                                lv = acc;
                                ls = 1'b1;
                            end
                        end
                    end
                    else if (is_cl)
                    begin
                        if (b == 8'h20 || b == 8'h09)
                        begin
                            if (vp == VP_DIGIT) vp = VP_TRAIL;
                        end
                        else if (b >= 8'h30 && b <= 8'h39 && vp != VP_TRAIL)
                        begin
                            if (acc10[35:32] != 4'd0) err = 1'b1;
                            else
                            begin
                                acc = acc10[31:0];
                                vp = VP_DIGIT;
                            end
                        end
                        else
                            err = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    role = RL_BODY;
                    if (bl != '0) bl = bl - 1'b1;
                    if (bl == '0) done = 1'b1;
                end
                default: err = 1'b1;
            endcase
        end

        st = err ? ST_ERR : (done ? ST_DONE : ST_MORE);
        out_next = {4'd0, 32'(tt), lv, hs, mn, 16'(pc), 16'(mc), hidx, role, st};

        phase_next = ph; lit_next = lit; pcr_next = pcr; mcnt_next = mc; pcnt_next = pc;
        minor_next = mn; hseen_next = hs; nmp_next = nmp; nm_next = nm; vp_next = vp;
        acc_next = acc; lval_next = lv; lseen_next = ls; bl_next = bl; tot_next = tt;
        if (st != ST_MORE)
        begin
            phase_next = PH_METHOD; lit_next = '0; pcr_next = 1'b0; mcnt_next = '0;
            pcnt_next = '0; minor_next = 1'b0; hseen_next = '0; nmp_next = '0;
            nm_next = 1'b1; vp_next = VP_LEAD; acc_next = '0; lval_next = '0;
            lseen_next = 1'b0; bl_next = '0; tot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD; lit_reg <= '0; pcr_reg <= 1'b0; mcnt_reg <= '0;
            pcnt_reg <= '0; minor_reg <= 1'b0; hseen_reg <= '0; nmp_reg <= '0;
            nm_reg <= 1'b1; vp_reg <= VP_LEAD; acc_reg <= '0; lval_reg <= '0;
            lseen_reg <= 1'b0; bl_reg <= '0; tot_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next; lit_reg <= lit_next; pcr_reg <= pcr_next;
                mcnt_reg <= mcnt_next; pcnt_reg <= pcnt_next; minor_reg <= minor_next;
                hseen_reg <= hseen_next; nmp_reg <= nmp_next; nm_reg <= nm_next;
                vp_reg <= vp_next; acc_reg <= acc_next; lval_reg <= lval_next;
                lseen_reg <= lseen_next; bl_reg <= bl_next; tot_reg <= tot_next;
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    // a body phase never starts without a declared length
    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> lval_reg != '0) else $error("body without length");
    // header count stays within the limit
    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        hseen_reg <= HDR_LIMIT) else $error("header count over limit");
    // a complete or malformed request leaves a cleared parser behind
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        take && out_next[1:0] != ST_MORE |=> phase_reg == PH_METHOD && tot_reg == '0)
        else $error("parser not cleared");
endmodule
`default_nettype wire
